[hdl/asmc_pkg.sv]
`default_nettype none

package asmc_pkg;

    // Matrix geometry
    localparam int MATRIX_SIDE = 16;
    localparam int COORD_W     = $clog2(MATRIX_SIDE);
    localparam int INDEX_W     = 2 * COORD_W;

    // Item kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_COMMAND = 2'd1;
    localparam logic [1:0] KIND_STOP    = 2'd2;
    localparam logic [1:0] KIND_QUERY   = 2'd3;

    // Command codes
    localparam logic [3:0] CMD_RED      = 4'd0;
    localparam logic [3:0] CMD_LAST     = 4'd3;

    // Display modes
    localparam logic [2:0] MODE_OFF         = 3'd0;
    localparam logic [2:0] MODE_RED         = 3'd1;
    localparam logic [2:0] MODE_GREEN_FIRST = 3'd2;
    localparam logic [2:0] MODE_GREEN_LAST  = 3'd4;
    localparam logic [2:0] MODE_YELLOW_OFS  = 3'd3;

    // Arrow directions
    localparam logic [1:0] DIR_STRAIGHT = 2'd1;
    localparam logic [1:0] DIR_LEFT     = 2'd2;
    localparam logic [1:0] DIR_RIGHT    = 2'd3;

    // Cycle phases
    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_GREEN  = 2'd1;
    localparam logic [1:0] PHASE_YELLOW = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_PHASE_TICKS = 2'd0;
    localparam logic [1:0] REG_BRIGHTNESS  = 2'd1;
    localparam logic [1:0] REG_FIRST_REV   = 2'd2;
    localparam logic [1:0] REG_SERPENTINE  = 2'd3;

    // Register reset values
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd1000;
    localparam logic [7:0]  BRIGHTNESS_RESET  = 8'd8;

    // Settings the pixel lookup needs
    typedef struct packed {
        logic [7:0] brightness;
        logic       first_row_reversed;
        logic       serpentine_rows;
    } pixel_cfg_t;

    // Left-pointing arrow: a is the column, b the row
    function automatic logic hit_left(input logic [COORD_W-1:0] a,
                                      input logic [COORD_W-1:0] b);
        logic [COORD_W:0] ax;
        logic [COORD_W:0] bx;
        logic             shaft;
        logic             upper;
        logic             lower;
        ax    = {1'b0, a};
        bx    = {1'b0, b};
        shaft = (ax >= 5'd5) && (ax <= 5'd14) && (bx >= 5'd7) && (bx <= 5'd8);
        upper = (bx + ax >= 5'd8) && (bx + ax <= 5'd9);
        lower = (bx >= ax + 5'd6) && (bx <= ax + 5'd7);
        return shaft || ((ax >= 5'd1) && (ax <= 5'd5) && (upper || lower));
    endfunction

endpackage

`default_nettype wire

[hdl/asmc_pixel.sv]
`default_nettype none

module asmc_pixel (
    input  wire logic [asmc_pkg::INDEX_W-1:0] led_index,
    input  wire logic [2:0]                   display_mode,
    input  wire asmc_pkg::pixel_cfg_t         cfg,
    output logic [7:0]                        red_level,
    output logic [7:0]                        green_level
);

    localparam int CW = asmc_pkg::COORD_W;

    logic [CW-1:0] y;
    logic [CW-1:0] px;
    logic [CW-1:0] x;
    logic          rtl;
    logic [1:0]    dir;
    logic          hit;
    logic          is_green;
    logic          is_yellow;

    // Undo the serpentine chain order
    always_comb
    begin
        y   = led_index[asmc_pkg::INDEX_W-1:CW];
        px  = led_index[CW-1:0];
        rtl = cfg.first_row_reversed ^ (cfg.serpentine_rows & y[0]);
        x   = rtl ? ~px : px;
    end

    // Pick the arrow direction from the mode
    always_comb
    begin
        is_green  = (display_mode >= asmc_pkg::MODE_GREEN_FIRST) &&
                    (display_mode <= asmc_pkg::MODE_GREEN_LAST);
        is_yellow = display_mode > asmc_pkg::MODE_GREEN_LAST;
        if (is_yellow)
        begin
            dir = 2'(display_mode - asmc_pkg::MODE_GREEN_LAST);
        end
        else
        begin
            dir = 2'(display_mode - asmc_pkg::MODE_RED);
        end
    end

    // Test the point against the shape
    always_comb
    begin
        case (dir)
            asmc_pkg::DIR_STRAIGHT: hit = asmc_pkg::hit_left(y, x);
            asmc_pkg::DIR_LEFT:     hit = asmc_pkg::hit_left(x, y);
            asmc_pkg::DIR_RIGHT:    hit = asmc_pkg::hit_left(~x, y);
            default:                hit = 1'b0;
        endcase
    end

    // Color the pixel
    always_comb
    begin
        red_level   = 8'd0;
        green_level = 8'd0;
        if (display_mode == asmc_pkg::MODE_RED)
        begin
            red_level = cfg.brightness;
        end
        else if (is_green && hit)
        begin
            green_level = cfg.brightness;
        end
        else if (is_yellow && hit)
        begin
            red_level   = cfg.brightness;
            green_level = cfg.brightness;
        end
    end

endmodule

`default_nettype wire

[hdl/arrow_signal_matrix_controller_top.sv]
`default_nettype none

// Arrow signal matrix controller for a 16x16 LED chain. Every input beat (tick,
// command, stop or pixel query) yields exactly one result beat, registered in the
// cycle after acceptance; one beat is taken per cycle, so the sustained rate is
// one item per clock, set by the single result register, which holds while the
// output side stalls and stalls the input side only then. Commands start red or
// a green arrow that turns yellow after phase_ticks ticks and then solid red;
// pixel queries map a chain position to x,y and test it against the arrow shape.
// Registers on the APB port: 0x0 phase_ticks, 0x4 brightness,
// 0x8 first_row_reversed, 0xC serpentine_rows.

module arrow_signal_matrix_controller_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [3:0]  command_code,
    input  wire logic [7:0]  led_index,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       red_level,
    output logic [7:0]       green_level,
    output logic [7:0]       blue_level,
    output logic [2:0]       shown_mode,
    output logic             cycle_busy,
    output logic             command_taken
);

    logic [15:0] phase_ticks_reg;
    logic [7:0]  brightness_reg;
    logic        first_rev_reg;
    logic        serpentine_reg;

    logic [2:0]  mode_reg;
    logic [2:0]  mode_next;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [15:0] elapsed_reg;
    logic [15:0] elapsed_next;
    logic [15:0] elapsed_inc;
    logic        taken_next;

    logic        out_valid_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [2:0]  mode_out_reg;
    logic        busy_reg;
    logic        taken_reg;

    logic [7:0]  pix_red;
    logic [7:0]  pix_green;
    logic        accept;
    logic        cfg_write;

    asmc_pkg::pixel_cfg_t pix_cfg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= asmc_pkg::PHASE_TICKS_RESET;
            brightness_reg  <= asmc_pkg::BRIGHTNESS_RESET;
            first_rev_reg   <= 1'b1;
            serpentine_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                asmc_pkg::REG_PHASE_TICKS: phase_ticks_reg <= pwdata[15:0];
                asmc_pkg::REG_BRIGHTNESS:  brightness_reg  <= pwdata[7:0];
                asmc_pkg::REG_FIRST_REV:   first_rev_reg   <= pwdata[0];
                asmc_pkg::REG_SERPENTINE:  serpentine_reg  <= pwdata[0];
                default:                   phase_ticks_reg <= phase_ticks_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr[3:2])
            asmc_pkg::REG_PHASE_TICKS: prdata = {16'd0, phase_ticks_reg};
            asmc_pkg::REG_BRIGHTNESS:  prdata = {24'd0, brightness_reg};
            asmc_pkg::REG_FIRST_REV:   prdata = {31'd0, first_rev_reg};
            asmc_pkg::REG_SERPENTINE:  prdata = {31'd0, serpentine_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // Signal cycle state update for one beat
    always_comb
    begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        taken_next   = 1'b0;
        elapsed_inc  = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
        case (kind)
            asmc_pkg::KIND_TICK:
            begin
                if (phase_reg != asmc_pkg::PHASE_IDLE)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= phase_ticks_reg)
                    begin
                        elapsed_next = 16'd0;
                        if ((phase_reg == asmc_pkg::PHASE_GREEN) &&
                            (mode_reg >= asmc_pkg::MODE_GREEN_FIRST) &&
                            (mode_reg <= asmc_pkg::MODE_GREEN_LAST))
                        begin
                            mode_next  = mode_reg + asmc_pkg::MODE_YELLOW_OFS;
                            phase_next = asmc_pkg::PHASE_YELLOW;
                        end
                        else
                        begin
                            mode_next  = asmc_pkg::MODE_RED;
                            phase_next = asmc_pkg::PHASE_IDLE;
                        end
                    end
                end
            end
            asmc_pkg::KIND_COMMAND:
            begin
                if ((command_code <= asmc_pkg::CMD_LAST) &&
                    (phase_reg == asmc_pkg::PHASE_IDLE))
                begin
                    taken_next   = 1'b1;
                    elapsed_next = 16'd0;
                    if (command_code == asmc_pkg::CMD_RED)
                    begin
                        mode_next = asmc_pkg::MODE_RED;
                    end
                    else
                    begin
                        mode_next  = asmc_pkg::MODE_RED + command_code[2:0];
                        phase_next = asmc_pkg::PHASE_GREEN;
                    end
                end
            end
            asmc_pkg::KIND_STOP:
            begin
                mode_next    = asmc_pkg::MODE_OFF;
                phase_next   = asmc_pkg::PHASE_IDLE;
                elapsed_next = 16'd0;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // Pixel lookup against the current mode
    always_comb
    begin
        pix_cfg.brightness         = brightness_reg;
        pix_cfg.first_row_reversed = first_rev_reg;
        pix_cfg.serpentine_rows    = serpentine_reg;
    end

    asmc_pixel u_pixel (
        .led_index    (led_index),
        .display_mode (mode_reg),
        .cfg          (pix_cfg),
        .red_level    (pix_red),
        .green_level  (pix_green)
    );

    // State registers: advance on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= asmc_pkg::MODE_OFF;
            phase_reg   <= asmc_pkg::PHASE_IDLE;
            elapsed_reg <= 16'd0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // Result valid: set on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_reg      <= (kind == asmc_pkg::KIND_QUERY) ? pix_red : 8'd0;
            green_reg    <= (kind == asmc_pkg::KIND_QUERY) ? pix_green : 8'd0;
            mode_out_reg <= mode_next;
            busy_reg     <= (phase_next != asmc_pkg::PHASE_IDLE);
            taken_reg    <= taken_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red_level     = red_reg;
    assign green_level   = green_reg;
    assign blue_level    = 8'd0;
    assign shown_mode    = mode_out_reg;
    assign cycle_busy    = busy_reg;
    assign command_taken = taken_reg;

endmodule

`default_nettype wire
